// File: hw/rtl/ggc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggc_pkg: shared types and constants of the gate gain computer
// Sequencer states, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package ggc_pkg;

    // defaults of the top level parameters
    localparam int HYSTERESIS_DB_DEF = 1536;
    localparam int HOLD_BITS_DEF     = 20;

    // port and datapath widths
    localparam int LEVEL_W     = 16;
    localparam int GAIN_W      = 24;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 18;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int QUO_W       = 28;
    localparam int REM_W       = 17;
    localparam int CNT_W       = 5;

    // arithmetic constants
    localparam logic [13:0]        KNEE_MAX  = 14'd12800;
    localparam logic [16:0]        ONE_Q16   = 17'h10000;
    localparam logic [17:0]        THREE_Q16 = 18'h30000;
    localparam logic [CNT_W-1:0]   BIN_DIV_STEPS = 5'd16;
    localparam logic [CNT_W-1:0]   EXP_DIV_STEPS = 5'd28;

    // mode register bits
    localparam int MODE_DUCK_BIT   = 0;
    localparam int MODE_LINREL_BIT = 1;
    localparam int MODE_BINARY_BIT = 2;

    // register reset values
    localparam logic signed [15:0] THRESHOLD_RST = 16'shD800;   // -40 dB
    localparam logic [19:0]        HOLD_RST      = 20'd0;
    localparam logic signed [15:0] RANGE_RST     = 16'shB000;   // -80 dB
    localparam logic [13:0]        KNEE_RST      = 14'd0;
    localparam logic [14:0]        SLOPE_RST     = 15'd256;
    localparam logic [15:0]        ATTACK_RST    = 16'd60000;
    localparam logic [15:0]        RELEASE_RST   = 16'd65000;
    localparam logic [2:0]         MODE_RST      = 3'd4;
    localparam logic signed [GAIN_W-1:0] GAIN_RST = 24'shB00000; // reset range in Q8.16

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD,
        REG_HOLD,
        REG_RANGE,
        REG_KNEE,
        REG_SLOPE,
        REG_ATTACK,
        REG_RELEASE,
        REG_MODE
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GATE,
        ST_DIV,
        ST_NSQ,
        ST_OPN,
        ST_OPQ,
        ST_TGT,
        ST_TGQ,
        ST_DSQ,
        ST_SDD,
        ST_SDV,
        ST_EXQ,
        ST_SLP,
        ST_SLQ,
        ST_RAMP,
        ST_RMUL,
        ST_RAPP,
        ST_OUT
    } state_t;

endpackage

// File: hw/rtl/gate_gain_computer.sv
// Paths: from an accepted word to its result word, an expander word above
// its knee or in hold that needs no ramp multiply takes the short path, the
// expander soft knee the long one.
// Flow: a new word is taken only once the last one is in the output register;
// the shared divider dominates the long paths, retiring one quotient bit per cycle (16 bits soft gate, 28 expander).
// Reset: synchronous, active low; clears the sequencer, gate state, output
// valid and loads the register defaults; gain starts at the default range.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_gain_computer: noise gate / downward expander gain computer
// Hysteresis gate with hold counter, hard/smoothstep knee gate or quadratic
// knee expander, attack/release smoothing, all on one shared multiplier and
// one shared restoring divider run by a small sequencer.
// ----------------------------------------------------------------------------
module gate_gain_computer #(
    parameter int HYSTERESIS_DB = ggc_pkg::HYSTERESIS_DB_DEF,
    parameter int HOLD_BITS     = ggc_pkg::HOLD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ggc_pkg::TDATA_IN_W-1:0]    s_tdata,   // [15:0] level_db
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ggc_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [15:0] gain_db, [16] gate_is_open
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ggc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ggc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int GW = ggc_pkg::GAIN_W;
    localparam logic signed [17:0] HYST = 18'(HYSTERESIS_DB);
    localparam logic [31:0] HOLD_MAX = 32'((64'd1 << HOLD_BITS) - 64'd1);

    // ---------------- configuration registers ----------------
    logic signed [15:0] threshold_reg;
    logic [19:0]        hold_samples_reg;
    logic signed [15:0] range_reg;
    logic [13:0]        knee_reg;
    logic [14:0]        slope_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;
    logic [2:0]         mode_reg;

    // ---------------- sequencer and datapath state ----------------
    ggc_pkg::state_t state_reg, state_next;
    logic                          open_reg, open_next;
    logic [HOLD_BITS-1:0]          hold_reg, hold_next;
    logic signed [GW-1:0]          gain_reg, gain_next;
    logic signed [GW-1:0]          target_reg, target_next;
    logic signed [15:0]            level_reg, level_next;
    logic [16:0]                   open_q_reg, open_q_next;
    logic [14:0]                   d_reg, d_next;
    logic [17:0]                   over_mag_reg, over_mag_next;
    logic [24:0]                   diff_mag_reg, diff_mag_next;
    logic [15:0]                   coef_reg, coef_next;
    logic                          up_reg, up_next;
    logic [ggc_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [ggc_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [ggc_pkg::QUO_W-1:0]     quo_reg, quo_next;
    logic [ggc_pkg::REM_W-1:0]     dvs_reg, dvs_next;
    logic [ggc_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          div_exp_reg, div_exp_next;
    logic                          m_valid_reg, m_valid_next;
    logic [15:0]                   m_gain_reg, m_gain_next;
    logic                          m_open_reg, m_open_next;

    // ---------------- derived configuration ----------------
    logic                 duck, linear_rel, binary;
    logic [13:0]          knee_eff;
    logic signed [15:0]   rng_eff;
    logic signed [GW-1:0] rng16;
    logic [15:0]          rng_neg;
    logic [GW-1:0]        rng_mag;
    logic [HOLD_BITS-1:0] hold_load;

    assign duck       = mode_reg[ggc_pkg::MODE_DUCK_BIT];
    assign linear_rel = mode_reg[ggc_pkg::MODE_LINREL_BIT];
    assign binary     = mode_reg[ggc_pkg::MODE_BINARY_BIT];
    // clamp knee to its widest setting and range to at most 0 dB
    assign knee_eff   = (knee_reg > ggc_pkg::KNEE_MAX) ? ggc_pkg::KNEE_MAX : knee_reg;
    assign rng_eff    = range_reg[15] ? range_reg : 16'sd0;
    assign rng16      = signed'({rng_eff, 8'h00});
    assign rng_neg    = 16'd0 - 16'(rng_eff);
    assign rng_mag    = {rng_neg, 8'h00};
    // saturate the hold time to the counter capacity
    assign hold_load  = HOLD_BITS'((32'(hold_samples_reg) > HOLD_MAX) ? HOLD_MAX
                                                                      : 32'(hold_samples_reg));

    // ---------------- configuration port ----------------
    // Writes must only arrive while the block is idle; the block does not enforce it and takes them at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= ggc_pkg::THRESHOLD_RST;
            hold_samples_reg <= ggc_pkg::HOLD_RST;
            range_reg        <= ggc_pkg::RANGE_RST;
            knee_reg         <= ggc_pkg::KNEE_RST;
            slope_reg        <= ggc_pkg::SLOPE_RST;
            attack_reg       <= ggc_pkg::ATTACK_RST;
            release_reg      <= ggc_pkg::RELEASE_RST;
            mode_reg         <= ggc_pkg::MODE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (ggc_pkg::reg_idx_t'(cfg_index))
                ggc_pkg::REG_THRESHOLD: threshold_reg    <= signed'(cfg_data[15:0]);
                ggc_pkg::REG_HOLD:      hold_samples_reg <= cfg_data[19:0];
                ggc_pkg::REG_RANGE:     range_reg        <= signed'(cfg_data[15:0]);
                ggc_pkg::REG_KNEE:      knee_reg         <= cfg_data[13:0];
                ggc_pkg::REG_SLOPE:     slope_reg        <= cfg_data[14:0];
                ggc_pkg::REG_ATTACK:    attack_reg       <= cfg_data[15:0];
                ggc_pkg::REG_RELEASE:   release_reg      <= cfg_data[15:0];
                ggc_pkg::REG_MODE:      mode_reg         <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // ---------------- gate comparator with hold counter ----------------
    logic                 lvl_ge_thr, lvl_ge_close;
    logic                 open_g, holding_g;
    logic [HOLD_BITS-1:0] hold_g;

    assign lvl_ge_thr   = level_reg >= threshold_reg;
    assign lvl_ge_close = 18'(level_reg) >= (18'(threshold_reg) - HYST);

    always_comb begin
        open_g = open_reg;
        hold_g = hold_reg;
        if (!open_reg && lvl_ge_thr) begin
            open_g = 1'b1;
            hold_g = hold_load;
        end else if (open_reg) begin
            if (lvl_ge_close) begin
                hold_g = hold_load;             // level still up: re-arm hold
            end else if (hold_reg != '0) begin
                hold_g = hold_reg - 1'b1;       // count the hold down
            end else begin
                open_g = 1'b0;                  // hold ran out: close
            end
        end
    end

    assign holding_g = open_g && (hold_g != '0);

    // ---------------- knee geometry ----------------
    // Gate soft knee: n = num / den with num = 2*(level - thr) + knee.
    logic signed [16:0] lvl_m_thr;
    logic signed [18:0] num_w, den_s;
    logic [14:0]        den_w;
    // Expander: level reflected about the threshold when ducking.
    logic signed [18:0] lev_w, over_w;
    logic [17:0]        over_mag_w;
    logic               in_knee;
    logic signed [20:0] d_w;

    assign lvl_m_thr  = 17'(level_reg) - 17'(threshold_reg);
    assign num_w      = (19'(lvl_m_thr) <<< 1) + signed'(19'(knee_eff));
    assign den_w      = {knee_eff, 1'b0};
    assign den_s      = signed'(19'(den_w));
    assign lev_w      = duck ? ((19'(threshold_reg) <<< 1) - 19'(level_reg)) : 19'(level_reg);
    assign over_w     = lev_w - 19'(threshold_reg);
    assign over_mag_w = over_w[18] ? 18'(-over_w) : over_w[17:0];
    // inside the knee when twice the distance to the threshold fits the knee
    assign in_knee    = (knee_eff != '0) && ({over_mag_w, 1'b0} <= 19'(knee_eff));
    assign d_w        = signed'(21'(knee_eff)) - (21'(over_w) <<< 1);

    // ---------------- shared multiplier ----------------
    // Operands are picked by state from registered values; the product is
    // always registered before anyone looks at it.
    logic [ggc_pkg::MUL_A_W-1:0] mul_a;
    logic [ggc_pkg::MUL_B_W-1:0] mul_b;
    logic                        mul_en;
    logic [16:0]                 tgt_b;

    // duck inverts openness, so the gain factor (1 - openness) flips too
    assign tgt_b = duck ? open_q_reg : (ggc_pkg::ONE_Q16 - open_q_reg);

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (state_reg)
            ggc_pkg::ST_NSQ: begin
                mul_a = 32'(quo_reg[15:0]);
                mul_b = 18'(quo_reg[15:0]);
            end
            ggc_pkg::ST_OPN: begin
                mul_a = prod_reg[31:0];
                mul_b = ggc_pkg::THREE_Q16 - {1'b0, quo_reg[15:0], 1'b0};
            end
            ggc_pkg::ST_TGT: begin
                mul_a = 32'(rng_mag);
                mul_b = 18'(tgt_b);
            end
            ggc_pkg::ST_DSQ: begin
                mul_a = 32'(d_reg);
                mul_b = 18'(d_reg);
            end
            ggc_pkg::ST_SDD: begin
                mul_a = prod_reg[31:0];
                mul_b = 18'(slope_reg);
            end
            ggc_pkg::ST_SLP: begin
                mul_a = 32'(over_mag_reg);
                mul_b = 18'(slope_reg);
            end
            ggc_pkg::ST_RMUL: begin
                mul_a = 32'(diff_mag_reg);
                mul_b = 18'(coef_reg);
            end
            default: mul_en = 1'b0;
        endcase
    end

    // ---------------- shared restoring divider, one bit per cycle ----------------
    logic [ggc_pkg::REM_W:0] div_t, div_sub;
    logic                    div_ge;

    assign div_t   = {rem_reg, quo_reg[ggc_pkg::QUO_W-1]};
    assign div_ge  = div_t >= {1'b0, dvs_reg};
    assign div_sub = div_t - {1'b0, dvs_reg};

    // ---------------- target and ramp arithmetic ----------------
    logic [39:0]          tgq_sum;
    logic [GW-1:0]        tgq_mag;
    logic signed [24:0]   diff_w;
    logic [24:0]          diff_mag_w;
    logic signed [25:0]   lin_w, rapp_w, step_w;

    // floor of a negative product: round the magnitude up
    assign tgq_sum    = prod_reg[39:0] + 40'hFFFF;
    assign tgq_mag    = tgq_sum[39:16];
    assign diff_w     = 25'(gain_reg) - 25'(target_reg);
    assign diff_mag_w = diff_w[24] ? 25'(-diff_w) : diff_w;
    assign lin_w      = 26'(gain_reg) - signed'(26'({release_reg, 8'h00}));
    // scaled distance, truncated toward zero
    assign step_w     = signed'(26'(prod_reg[40:16]));
    assign rapp_w     = up_reg ? (26'(target_reg) - step_w) : (26'(target_reg) + step_w);

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ggc_pkg::ST_IDLE;
            open_reg    <= 1'b0;
            hold_reg    <= '0;
            gain_reg    <= ggc_pkg::GAIN_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            hold_reg    <= hold_next;
            gain_reg    <= gain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg   <= target_next;
        level_reg    <= level_next;
        open_q_reg   <= open_q_next;
        d_reg        <= d_next;
        over_mag_reg <= over_mag_next;
        diff_mag_reg <= diff_mag_next;
        coef_reg     <= coef_next;
        up_reg       <= up_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        cnt_reg      <= cnt_next;
        div_exp_reg  <= div_exp_next;
        m_gain_reg   <= m_gain_next;
        m_open_reg   <= m_open_next;
    end

    always_comb begin
        state_next    = state_reg;
        open_next     = open_reg;
        hold_next     = hold_reg;
        gain_next     = gain_reg;
        target_next   = target_reg;
        level_next    = level_reg;
        open_q_next   = open_q_reg;
        d_next        = d_reg;
        over_mag_next = over_mag_reg;
        diff_mag_next = diff_mag_reg;
        coef_next     = coef_reg;
        up_next       = up_reg;
        prod_next     = mul_en ? (50'(mul_a) * 50'(mul_b)) : prod_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        div_exp_next  = div_exp_reg;
        m_valid_next  = m_valid_reg;
        m_gain_next   = m_gain_reg;
        m_open_next   = m_open_reg;

        // drop the output word once the sink takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ggc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    level_next = s_tdata;
                    state_next = ggc_pkg::ST_GATE;
                end
            end

            // update the gate and pick the target path
            ggc_pkg::ST_GATE: begin
                open_next = open_g;
                hold_next = hold_g;
                if (binary) begin
                    if (holding_g) begin
                        open_q_next = ggc_pkg::ONE_Q16;
                        state_next  = ggc_pkg::ST_TGT;
                    end else if (knee_eff == '0) begin
                        open_q_next = open_g ? ggc_pkg::ONE_Q16 : 17'd0;
                        state_next  = ggc_pkg::ST_TGT;
                    end else if (num_w <= 19'sd0) begin
                        open_q_next = 17'd0;
                        state_next  = ggc_pkg::ST_TGT;
                    end else if (num_w >= den_s) begin
                        open_q_next = ggc_pkg::ONE_Q16;
                        state_next  = ggc_pkg::ST_TGT;
                    end else begin
                        // n = (num << 16) / den: num < den, so 16 quotient bits
                        rem_next     = ggc_pkg::REM_W'(num_w[14:0]);
                        quo_next     = '0;
                        dvs_next     = ggc_pkg::REM_W'(den_w);
                        cnt_next     = ggc_pkg::BIN_DIV_STEPS;
                        div_exp_next = 1'b0;
                        state_next   = ggc_pkg::ST_DIV;
                    end
                end else begin
                    if (holding_g) begin
                        target_next = duck ? rng16 : '0;
                        state_next  = ggc_pkg::ST_RAMP;
                    end else if (in_knee) begin
                        d_next     = d_w[14:0];
                        state_next = ggc_pkg::ST_DSQ;
                    end else if (!over_w[18]) begin
                        target_next = '0;
                        state_next  = ggc_pkg::ST_RAMP;
                    end else begin
                        over_mag_next = over_mag_w;
                        state_next    = ggc_pkg::ST_SLP;
                    end
                end
            end

            ggc_pkg::ST_DIV: begin
                rem_next = div_ge ? div_sub[ggc_pkg::REM_W-1:0] : div_t[ggc_pkg::REM_W-1:0];
                quo_next = {quo_reg[ggc_pkg::QUO_W-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == ggc_pkg::CNT_W'(1)) begin
                    state_next = div_exp_reg ? ggc_pkg::ST_EXQ : ggc_pkg::ST_NSQ;
                end
            end

            // smoothstep: openness = n*n*(3 - 2n)
            ggc_pkg::ST_NSQ: state_next = ggc_pkg::ST_OPN;
            ggc_pkg::ST_OPN: state_next = ggc_pkg::ST_OPQ;
            ggc_pkg::ST_OPQ: begin
                open_q_next = prod_reg[48:32];
                state_next  = ggc_pkg::ST_TGT;
            end
            ggc_pkg::ST_TGT: state_next = ggc_pkg::ST_TGQ;
            ggc_pkg::ST_TGQ: begin
                target_next = GW'(24'd0 - tgq_mag);
                state_next  = ggc_pkg::ST_RAMP;
            end

            // expander knee: slope * d * d / (8 * knee)
            ggc_pkg::ST_DSQ: state_next = ggc_pkg::ST_SDD;
            ggc_pkg::ST_SDD: state_next = ggc_pkg::ST_SDV;
            ggc_pkg::ST_SDV: begin
                // quotient stays below 2^28, so the top bits seed the remainder
                rem_next     = prod_reg[44:28];
                quo_next     = prod_reg[27:0];
                dvs_next     = {knee_eff, 3'b000};
                cnt_next     = ggc_pkg::EXP_DIV_STEPS;
                div_exp_next = 1'b1;
                state_next   = ggc_pkg::ST_DIV;
            end
            ggc_pkg::ST_EXQ: begin
                target_next = ({1'b0, quo_reg} > 29'(rng_mag)) ? rng16
                                                               : GW'(24'd0 - quo_reg[23:0]);
                state_next  = ggc_pkg::ST_RAMP;
            end

            // below the knee: slope * (level - thr), floored at range
            ggc_pkg::ST_SLP: state_next = ggc_pkg::ST_SLQ;
            ggc_pkg::ST_SLQ: begin
                target_next = (prod_reg > ggc_pkg::PROD_W'(rng_mag)) ? rng16
                                                                   : GW'(24'd0 - prod_reg[23:0]);
                state_next  = ggc_pkg::ST_RAMP;
            end

            // attack when rising, release when falling
            ggc_pkg::ST_RAMP: begin
                if (diff_w == 25'sd0) begin
                    state_next = ggc_pkg::ST_OUT;
                end else if (diff_w[24]) begin
                    diff_mag_next = diff_mag_w;
                    coef_next     = attack_reg;
                    up_next       = 1'b1;
                    state_next    = ggc_pkg::ST_RMUL;
                end else if (linear_rel) begin
                    gain_next  = (lin_w > 26'(target_reg)) ? lin_w[GW-1:0] : target_reg;
                    state_next = ggc_pkg::ST_OUT;
                end else begin
                    diff_mag_next = diff_mag_w;
                    coef_next     = release_reg;
                    up_next       = 1'b0;
                    state_next    = ggc_pkg::ST_RMUL;
                end
            end
            ggc_pkg::ST_RMUL: state_next = ggc_pkg::ST_RAPP;
            ggc_pkg::ST_RAPP: begin
                gain_next  = rapp_w[GW-1:0];
                state_next = ggc_pkg::ST_OUT;
            end

            // hold until the output register is free, then load it
            ggc_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_gain_next  = gain_reg[GW-1] ? gain_reg[GW-1:8] : 16'd0;
                    m_open_next  = open_reg;
                    state_next   = ggc_pkg::ST_IDLE;
                end
            end

            default: state_next = ggc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- ports ----------------
    assign s_tready = (state_reg == ggc_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_open_reg, m_gain_reg};

endmodule

// File: hw/rtl/ggc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggc_checker: port-level checks of the gate gain computer
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module ggc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ggc_pkg::TDATA_OUT_W-1:0]   m_tdata
);

    // one word in flight: input closes right after a word is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // gain never above 0 dB
    a_gain_nonpos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15] || (m_tdata[15:0] == 16'd0)))
        else $error("positive gain on output");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:17] == 7'd0))
        else $error("nonzero pad bits in output word");

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output word changed");

    // after reset: idle and ready, nothing on the output
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("block not idle after reset");

endmodule

bind gate_gain_computer ggc_checker u_ggc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
